[design/assert_macros.svh]
// assertion macros used by the receiver rtl
// no dependencies; simulation builds check, SYNTH builds drop them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define LFPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define LFPR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LFPR_ASSERT(label, prop, msg)
`define LFPR_NEVER(label, cond, msg)
`endif

`endif

[design/lfpr_pkg.sv]
// types and constants of the length framed packet receiver
// no dependencies; used by the top level
package lfpr_pkg;

  // parse phases; drain reads the stored payload out after a good checksum
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_DRAIN
  } phase_e;

  // configuration register indexes
  localparam logic [1:0] CFG_FIRST_HEAD  = 2'd0;
  localparam logic [1:0] CFG_SECOND_HEAD = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd3;

  // input kinds carried in tuser
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0]  FIRST_HEAD_RST  = 8'd170;
  localparam logic [7:0]  SECOND_HEAD_RST = 8'd85;
  localparam logic [5:0]  MAX_LEN_RST     = 6'd32;
  localparam logic [15:0] TIMEOUT_RST     = 16'd10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_W      = 6;
  localparam int IDX_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int TICK_W     = 16;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - BYTE_W - IDX_W - LEN_W;

endpackage

[design/lfpr_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module lfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/length_framed_packet_receiver.sv]
// length framed packet receiver: HEAD1 HEAD2 LEN DATA[LEN] CHECKSUM, payload kept in lfpr_ram
// throughput: one byte or tick request per cycle while parsing; a good checksum byte starts a
// readout of LEN results, one ram read at a time, each issued only when the output register
// is free, and input is held off until the last read has landed
// each read result lands in the ram read register, then in the output register
// reset (async, active low) clears control state and loads register defaults; ram not cleared
`include "assert_macros.svh"

module length_framed_packet_receiver #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [lfpr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfpr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input requests
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // rx_byte [7:0]
  input  logic                              s_axis_tuser,  // command [0]
  // result requests
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // payload_byte [7:0], payload_index [12:8], payload_length [18:13], zero pad [23:19]
  output logic [lfpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast   // last_of_frame
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  // largest length that fits the store, as a byte
  localparam logic [7:0] StoreMax = 8'(MAX_PAYLOAD);

  // configuration registers
  logic [7:0]  first_head_q;
  logic [7:0]  second_head_q;
  logic [5:0]  max_len_q;
  logic [15:0] timeout_q;

  // parser state
  lfpr_pkg::phase_e phase_q, phase_d;
  logic [5:0]  taken_q, taken_d;
  logic [5:0]  frame_len_q, frame_len_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] ticks_q, ticks_d;

  // readout state
  logic [5:0]  rd_idx_q, rd_idx_d;
  logic        pend_q;
  logic [4:0]  pend_idx_q;
  logic        pend_last_q;

  // output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [4:0]  out_idx_q;
  logic [5:0]  out_len_q;
  logic        out_last_q;

  // ram side
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic        in_fire;
  logic        in_drain;
  logic [7:0]  rx_byte;
  logic [7:0]  sum_add;
  logic [15:0] ticks_sat;
  logic [5:0]  taken_inc;
  logic        len_ok;
  logic [4:0]  out_last_idx;

  assign rx_byte       = s_axis_tdata;
  assign in_drain      = (phase_q == lfpr_pkg::PH_DRAIN);
  assign s_axis_tready = !in_drain;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign sum_add       = sum_q + rx_byte;
  assign ticks_sat     = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign taken_inc     = taken_q + 6'd1;
  assign len_ok        = (rx_byte != 8'd0) && (rx_byte <= {2'b00, max_len_q})
                         && (rx_byte <= StoreMax);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_head_q  <= lfpr_pkg::FIRST_HEAD_RST;
      second_head_q <= lfpr_pkg::SECOND_HEAD_RST;
      max_len_q     <= lfpr_pkg::MAX_LEN_RST;
      timeout_q     <= lfpr_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfpr_pkg::CFG_FIRST_HEAD:  first_head_q  <= cfg_data_i[7:0];
        lfpr_pkg::CFG_SECOND_HEAD: second_head_q <= cfg_data_i[7:0];
        lfpr_pkg::CFG_MAX_LEN:     max_len_q     <= cfg_data_i[5:0];
        lfpr_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parse and readout control
  always_comb begin
    phase_d     = phase_q;
    taken_d     = taken_q;
    frame_len_d = frame_len_q;
    sum_d       = sum_q;
    ticks_d     = ticks_q;
    rd_idx_d    = rd_idx_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (in_fire && (s_axis_tuser == lfpr_pkg::CMD_TICK)) begin
      // tick: count idle time, abandon a partial frame at the timeout
      ticks_d = ticks_sat;
      if ((phase_q != lfpr_pkg::PH_IDLE) && (ticks_sat >= timeout_q)) begin
        phase_d = lfpr_pkg::PH_IDLE;
      end
    end else if (in_fire) begin
      ticks_d = '0;
      case (phase_q)
        lfpr_pkg::PH_IDLE: begin
          if (rx_byte == first_head_q) begin
            taken_d     = '0;
            frame_len_d = '0;
            sum_d       = rx_byte;
            phase_d     = lfpr_pkg::PH_HEAD;
          end
        end
        lfpr_pkg::PH_HEAD: begin
          // second header is tested first; a repeated first header holds
          if (rx_byte == second_head_q) begin
            sum_d   = sum_add;
            phase_d = lfpr_pkg::PH_LEN;
          end else if (rx_byte != first_head_q) begin
            phase_d = lfpr_pkg::PH_IDLE;
          end
        end
        lfpr_pkg::PH_LEN: begin
          sum_d   = sum_add;
          taken_d = '0;
          if (len_ok) begin
            frame_len_d = rx_byte[5:0];
            phase_d     = lfpr_pkg::PH_DATA;
          end else begin
            frame_len_d = rx_byte[5:0];
            phase_d     = lfpr_pkg::PH_IDLE;
          end
        end
        lfpr_pkg::PH_DATA: begin
          ram_we  = ({2'b00, taken_q} < StoreMax);
          taken_d = taken_inc;
          sum_d   = sum_add;
          if (taken_inc >= frame_len_q) begin
            phase_d = lfpr_pkg::PH_SUM;
          end
        end
        lfpr_pkg::PH_SUM: begin
          sum_d    = sum_add;
          rd_idx_d = '0;
          phase_d  = (sum_add == 8'd0) ? lfpr_pkg::PH_DRAIN : lfpr_pkg::PH_IDLE;
        end
        default: begin
          phase_d = lfpr_pkg::PH_IDLE;
        end
      endcase
    end else if (in_drain) begin
      // one read at a time, issued only when its data can land in the output register
      if ((rd_idx_q != frame_len_q) && !pend_q && (!out_valid_q || m_axis_tready)) begin
        ram_re   = 1'b1;
        rd_idx_d = rd_idx_q + 6'd1;
      end
      if ((rd_idx_q == frame_len_q) && !pend_q) begin
        phase_d = lfpr_pkg::PH_IDLE;
      end
    end
  end

  assign ram_waddr = AW'(taken_q);
  assign ram_raddr = AW'(rd_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lfpr_pkg::PH_IDLE;
      taken_q     <= '0;
      frame_len_q <= '0;
      sum_q       <= '0;
      ticks_q     <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      taken_q     <= taken_d;
      frame_len_q <= frame_len_d;
      sum_q       <= sum_d;
      ticks_q     <= ticks_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= ram_re;
      // a landing read always finds the output register free
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers of the read in flight and of the output
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      pend_idx_q  <= rd_idx_q[4:0];
      pend_last_q <= (rd_idx_d == frame_len_q);
    end
    if (pend_q) begin
      out_byte_q <= ram_rdata;
      out_idx_q  <= pend_idx_q;
      out_len_q  <= frame_len_q;
      out_last_q <= pend_last_q;
    end
  end

  lfpr_ram #(
    .WIDTH (lfpr_pkg::BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{lfpr_pkg::OUT_PAD_W{1'b0}}, out_len_q, out_idx_q, out_byte_q};

  // index the last byte of the held frame must carry
  assign out_last_idx = 5'(out_len_q - 6'd1);

  `LFPR_ASSERT(a_land_slot_free, pend_q |-> !out_valid_q, "read landed on a held result")
  `LFPR_ASSERT(a_drain_blocks_in, in_drain |-> !s_axis_tready, "input taken during readout")
  `LFPR_NEVER(a_rd_beyond_len, in_drain && (rd_idx_q > frame_len_q), "readout past length")
  `LFPR_ASSERT(a_last_index, (out_valid_q && out_last_q) |-> (out_idx_q == out_last_idx), "bad last")
  `LFPR_NEVER(a_write_in_drain, ram_we && in_drain, "store written during readout")

endmodule

[test/testbench.sv]
// self-checking testbench for the length framed packet receiver
// drives byte and tick requests, predicts payload results and compares them in order
// depends on lfpr_pkg and length_framed_packet_receiver
module testbench;

  localparam int MAX_PAYLOAD    = 32;
  localparam int PHASE_REQUESTS = 120;
  // margin for the readout of a full frame, during which the block holds its input off
  localparam int SETTLE_CYCLES  = 2 * MAX_PAYLOAD + 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // one payload result as the block reports it
  typedef struct packed {
    logic [7:0] data;
    logic [4:0] index;
    logic [5:0] length;
    logic       last;
  } payload_beat_t;

  // one row of the directed stimulus; typed rows carry their own expectation
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       typed;
    logic       has_result;
    logic [7:0] exp_byte;
  } directed_row_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [lfpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = lfpr_pkg::CFG_FIRST_HEAD;
  logic [lfpr_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = '0;  // rx_byte [7:0]
  logic                            s_axis_tuser  = lfpr_pkg::CMD_BYTE;  // command [0]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // payload_byte [7:0], payload_index [12:8], payload_length [18:13], zero pad [23:19]
  logic [lfpr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;  // last_of_frame

  length_framed_packet_receiver dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the configuration
  logic [7:0]  head1_cfg;
  logic [7:0]  head2_cfg;
  logic [5:0]  max_len_cfg;
  logic [15:0] timeout_cfg;

  // predictor copy of the parse state
  lfpr_pkg::phase_e parse_state = lfpr_pkg::PH_IDLE;
  logic [7:0]  stored_payload [MAX_PAYLOAD];
  logic [5:0]  taken_count  = '0;
  logic [5:0]  len_field    = '0;
  logic [7:0]  check_sum    = '0;
  logic [15:0] tick_count   = '0;

  payload_beat_t payload_expected [$];

  int unsigned tx_gap_pct     = 21;
  int unsigned rx_stall_pct   = 71;
  int unsigned rx_hold_cycles = 0;
  int unsigned frame_requests = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;

  // directed rows, run with reset headers and a gap timeout of one tick
  directed_row_t directed_rows [0:25] = '{
    '{lfpr_pkg::CMD_TICK, 8'h00,                     1'b1, 1'b0, 8'h00},  // tick while idle
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::FIRST_HEAD_RST,  1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::FIRST_HEAD_RST,  1'b0, 1'b0, 8'h00},  // repeated head kept
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::SECOND_HEAD_RST, 1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h01,                     1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h7f,                     1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h81,                     1'b1, 1'b1, 8'h7f},  // good sum, one out
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::FIRST_HEAD_RST,  1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h12,                     1'b1, 1'b0, 8'h00},  // wrong second head
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::FIRST_HEAD_RST,  1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::SECOND_HEAD_RST, 1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h00,                     1'b1, 1'b0, 8'h00},  // zero length
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::FIRST_HEAD_RST,  1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::SECOND_HEAD_RST, 1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'hff,                     1'b1, 1'b0, 8'h00},  // length far above
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::FIRST_HEAD_RST,  1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::SECOND_HEAD_RST, 1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h01,                     1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'hff,                     1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h00,                     1'b1, 1'b0, 8'h00},  // nonzero sum
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::FIRST_HEAD_RST,  1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_TICK, 8'hff,                     1'b1, 1'b0, 8'h00},  // timeout abandons
    '{lfpr_pkg::CMD_BYTE, lfpr_pkg::SECOND_HEAD_RST, 1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h01,                     1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h00,                     1'b0, 1'b0, 8'h00},
    '{lfpr_pkg::CMD_BYTE, 8'h00,                     1'b1, 1'b0, 8'h00}   // no frame open
  };

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // parser prediction for one accepted request; results go to the queue when kept
  task automatic predict_request(input logic cmd, input logic [7:0] value, input bit keep);
    int i;
    if (cmd == lfpr_pkg::CMD_TICK) begin
      if (tick_count != 16'hffff) tick_count++;
      if (parse_state != lfpr_pkg::PH_IDLE && tick_count >= timeout_cfg)
        parse_state = lfpr_pkg::PH_IDLE;
      return;
    end
    tick_count = '0;
    case (parse_state)
      lfpr_pkg::PH_IDLE: begin
        if (value == head1_cfg) begin
          taken_count = '0;
          len_field   = '0;
          check_sum   = value;
          parse_state = lfpr_pkg::PH_HEAD;
        end
      end
      lfpr_pkg::PH_HEAD: begin
        // second header is tested before the repeated first header
        if (value == head2_cfg) begin
          check_sum   = check_sum + value;
          parse_state = lfpr_pkg::PH_LEN;
        end else if (value != head1_cfg) begin
          parse_state = lfpr_pkg::PH_IDLE;
        end
      end
      lfpr_pkg::PH_LEN: begin
        check_sum   = check_sum + value;
        taken_count = '0;
        if (value >= 8'd1 && value <= {2'b00, max_len_cfg} && value <= 8'(MAX_PAYLOAD)) begin
          len_field   = value[5:0];
          parse_state = lfpr_pkg::PH_DATA;
        end else begin
          len_field   = value[5:0];
          parse_state = lfpr_pkg::PH_IDLE;
        end
      end
      lfpr_pkg::PH_DATA: begin
        if (taken_count < 6'(MAX_PAYLOAD)) stored_payload[taken_count[4:0]] = value;
        taken_count++;
        check_sum = check_sum + value;
        if (taken_count >= len_field) parse_state = lfpr_pkg::PH_SUM;
      end
      lfpr_pkg::PH_SUM: begin
        check_sum = check_sum + value;
        if (check_sum == 8'h00 && keep) begin
          for (i = 0; i < int'(len_field) && i < MAX_PAYLOAD; i++)
            payload_expected.push_back('{stored_payload[i[4:0]], i[4:0], len_field,
                                          (i + 1 == int'(len_field))});
        end
        parse_state = lfpr_pkg::PH_IDLE;
      end
      default: parse_state = lfpr_pkg::PH_IDLE;
    endcase
  endtask

  // offer one request after a random gap and wait for its handshake
  task automatic push_request(input logic cmd, input logic [7:0] value, input bit keep);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    frame_requests++;
    predict_request(cmd, value, keep);
  endtask

  task automatic send_byte(input logic [7:0] value);
    push_request(lfpr_pkg::CMD_BYTE, value, 1'b1);
  endtask

  // tick with a random don't-care byte
  task automatic send_tick();
    push_request(lfpr_pkg::CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // occasional ticks between frame bytes
  task automatic maybe_ticks();
    if ($urandom_range(0, 99) < 8) repeat ($urandom_range(1, 3)) send_tick();
  endtask

  task automatic write_reg(input logic [lfpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfpr_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [5:0] max_len, input logic [15:0] timeout);
    write_reg(lfpr_pkg::CFG_FIRST_HEAD, {8'h00, h1});
    write_reg(lfpr_pkg::CFG_SECOND_HEAD, {8'h00, h2});
    write_reg(lfpr_pkg::CFG_MAX_LEN, {10'h000, max_len});
    write_reg(lfpr_pkg::CFG_TIMEOUT, timeout);
    cfg_we_i    <= 1'b0;
    head1_cfg   = h1;
    head2_cfg   = h2;
    max_len_cfg = max_len;
    timeout_cfg = timeout;
  endtask

  // one frame, mostly well formed with random content, sometimes broken or plain noise
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned cap;
    int unsigned pick;
    int unsigned noise;
    int unsigned n;
    logic [7:0]  sum;
    logic [7:0]  value;
    kind = $urandom_range(0, 99);
    if (kind >= 93) begin
      // line noise, not counted toward the frame requests
      noise = $urandom_range(1, 4);
      repeat (noise) begin
        if ($urandom_range(0, 3) == 0) send_tick();
        else send_byte(8'($urandom_range(0, 255)));
      end
      frame_requests -= noise;
      return;
    end
    send_byte(head1_cfg);
    if ($urandom_range(0, 9) == 0) send_byte(head1_cfg);
    maybe_ticks();
    if (kind >= 88) begin
      // broken second header
      value = 8'($urandom_range(0, 255));
      if (value == head2_cfg) value = ~value;
      send_byte(value);
      return;
    end
    send_byte(head2_cfg);
    sum = head1_cfg + head2_cfg;
    maybe_ticks();
    if (kind >= 80) begin
      // length out of range: zero, above the max, or above the store size
      if (int'(max_len_cfg) < MAX_PAYLOAD && $urandom_range(0, 2) != 0)
        len = $urandom_range(32'(max_len_cfg) + 1, 255);
      else if ($urandom_range(0, 1) == 0) len = 0;
      else len = $urandom_range(MAX_PAYLOAD + 1, 255);
      send_byte(len[7:0]);
      return;
    end
    // mostly short frames, now and then the largest allowed
    cap  = (max_len_cfg < 6'd4) ? 32'(max_len_cfg) : 4;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 32'(max_len_cfg);
    else if (pick < 3) len = $urandom_range(1, 32'(max_len_cfg));
    else len = $urandom_range(1, cap);
    send_byte(len[7:0]);
    sum = sum + len[7:0];
    for (n = 0; n < len; n++) begin
      maybe_ticks();
      value = 8'($urandom_range(0, 255));
      send_byte(value);
      sum = sum + value;
    end
    maybe_ticks();
    value = 8'h00 - sum;
    if (kind >= 70) value = value + 8'($urandom_range(1, 255));  // corrupt the checksum
    send_byte(value);
  endtask

  // one-byte frame with a run of ticks after the first header
  task automatic send_gap_frame(input int unsigned ticks);
    logic [7:0] value;
    value = 8'($urandom_range(0, 255));
    send_byte(head1_cfg);
    repeat (ticks) send_tick();
    send_byte(head2_cfg);
    send_byte(8'h01);
    send_byte(value);
    send_byte(8'h00 - head1_cfg - head2_cfg - 8'h01 - value);
  endtask

  // bring the parser back to idle with bytes that never start a header
  task automatic flush_parse();
    while (parse_state != lfpr_pkg::PH_IDLE) send_byte(~head1_cfg);
  endtask

  // wait until every predicted result has been taken and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (payload_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned tx_gap, input int unsigned rx_stall,
                           input logic [7:0] h1, input logic [7:0] h2,
                           input logic [5:0] max_len, input logic [15:0] timeout,
                           input int unsigned hold);
    int unsigned start;
    apply_config(h1, h2, max_len, timeout);
    tx_gap_pct     = tx_gap;
    rx_stall_pct   = rx_stall;
    rx_hold_cycles = hold;
    start          = frame_requests;
    while (frame_requests - start < PHASE_REQUESTS) send_random_frame();
    flush_parse();
    settle();
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    payload_beat_t want;
    if (payload_expected.size() == 0) begin
      report_mismatch("unexpected result", m_axis_tdata, '0);
      return;
    end
    want = payload_expected.pop_front();
    if (m_axis_tdata[7:0] !== want.data)
      report_mismatch("payload_byte", 24'(m_axis_tdata[7:0]), 24'(want.data));
    if (m_axis_tdata[12:8] !== want.index)
      report_mismatch("payload_index", 24'(m_axis_tdata[12:8]), 24'(want.index));
    if (m_axis_tdata[18:13] !== want.length)
      report_mismatch("payload_length", 24'(m_axis_tdata[18:13]), 24'(want.length));
    if (m_axis_tdata[23:19] !== '0)
      report_mismatch("tdata pad", 24'(m_axis_tdata[23:19]), '0);
    if (m_axis_tlast !== want.last)
      report_mismatch("last_of_frame", 24'(m_axis_tlast), 24'(want.last));
  endtask

  // result side: check at the handshake edge, then pick the next ready
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result();
    if (rx_hold_cycles > 0) begin
      // long hold-off so the block fills up and stalls its input
      m_axis_tready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // watchdog on cycles with no request accepted on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[length_framed_packet_receiver] ERROR");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t row;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset headers and length, shortest gap timeout for the directed rows
    apply_config(lfpr_pkg::FIRST_HEAD_RST, lfpr_pkg::SECOND_HEAD_RST,
                 lfpr_pkg::MAX_LEN_RST, 16'd1);
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      push_request(row.cmd, row.data, !row.typed);
      if (row.typed && row.has_result)
        payload_expected.push_back('{row.exp_byte, 5'd0, 6'd1, 1'b1});
    end
    flush_parse();
    settle();

    // sender idles a little, receiver a lot; smallest length and timeout
    run_phase(21, 71, 8'h00, 8'hff, 6'd1, 16'd1, 0);
    // sender idles a lot, receiver a little; largest length, short timeouts
    run_phase(71, 21, 8'hff, 8'h00, 6'd32, 16'($urandom_range(2, 12)), 0);
    // no idling, random headers, largest timeout, one long receiver hold-off
    run_phase(0, 0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              6'($urandom_range(1, 32)), 16'hffff, 400);

    // gap timeout edge: one tick short keeps the frame, the full count drops it
    apply_config(lfpr_pkg::FIRST_HEAD_RST, lfpr_pkg::SECOND_HEAD_RST,
                 lfpr_pkg::MAX_LEN_RST, 16'd6);
    send_gap_frame(5);
    send_gap_frame(6);
    flush_parse();
    settle();

    if (error_count == 0) begin
      $display("[length_framed_packet_receiver] OK");
    end else begin
      $display("[length_framed_packet_receiver] ERROR");
    end
    $finish;
  end

endmodule
